// ----- rtl/stl_pkg.sv -----
// shared types, constants and codes for the sorted table interval locator
`default_nettype none

package stl_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int LEN_W    = 11;
    localparam int IDX_W    = 10;
    localparam int ITEM_W   = 32;
    localparam int STATUS_W = 2;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_LOCATE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSIDE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BELOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABOVE  = 2'd2;

    typedef struct packed {
        logic                     req_type;
        logic [IDX_W-1:0]         entry_index;
        logic signed [ITEM_W-1:0] item_value;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0]    interval_index;
        logic [STATUS_W-1:0] locate_status;
    } t_result;

    // control that travels with every beat down the pipeline
    typedef struct packed {
        logic                valid;
        logic                locate;
        logic                write;
        logic                done;
        logic [STATUS_W-1:0] status;
    } t_ctl;

endpackage

`default_nettype wire

// ----- rtl/stl_range.sv -----
// range check stage: compares the value against the first and last entries in use
`default_nettype none

module stl_range #(
    parameter int TABLE_DEPTH = stl_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = stl_pkg::VALUE_WIDTH_DEF,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire stl_pkg::t_ctl           i_ctl,
    input  wire logic signed [VALUE_WIDTH-1:0] i_key,
    input  wire logic [AW-1:0]           i_widx,
    input  wire logic [AW-1:0]           i_last,
    output stl_pkg::t_ctl                o_ctl,
    output logic signed [VALUE_WIDTH-1:0] o_key,
    output logic [AW-1:0]                o_widx,
    output logic [AW-1:0]                o_lo,
    output logic [AW-1:0]                o_hi
);

    logic signed [VALUE_WIDTH-1:0] r_mem [TABLE_DEPTH];
    logic signed [VALUE_WIDTH-1:0] r_first;
    logic signed [VALUE_WIDTH-1:0] r_lastval;
    logic signed [VALUE_WIDTH-1:0] r_key;
    logic [AW-1:0]                 r_widx;
    logic [AW-1:0]                 r_last;
    stl_pkg::t_ctl                 r_ctl;
    stl_pkg::t_ctl                 n_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= i_key;
        r_widx    <= i_widx;
        r_last    <= i_last;
        r_first   <= r_mem[0];
        r_lastval <= r_mem[i_last];
        if (i_ctl.valid && i_ctl.write) begin
            r_mem[i_widx] <= i_key;
        end
    end

    always_comb begin
        n_ctl        = r_ctl;
        n_ctl.status = stl_pkg::ST_INSIDE;
        if (r_key <= r_first) begin
            n_ctl.status = stl_pkg::ST_BELOW;
        end else if (r_key >= r_lastval) begin
            n_ctl.status = stl_pkg::ST_ABOVE;
        end
        // out of range and non-locate beats ride through the search untouched
        n_ctl.done = !r_ctl.locate || (n_ctl.status != stl_pkg::ST_INSIDE);
    end

    assign o_ctl  = n_ctl;
    assign o_key  = r_key;
    assign o_widx = r_widx;
    assign o_lo   = '0;
    assign o_hi   = r_last;

endmodule

`default_nettype wire

// ----- rtl/stl_step.sv -----
// one bisection stage with its own copy of the breakpoint table
`default_nettype none

module stl_step #(
    parameter int TABLE_DEPTH = stl_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = stl_pkg::VALUE_WIDTH_DEF,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire stl_pkg::t_ctl           i_ctl,
    input  wire logic signed [VALUE_WIDTH-1:0] i_key,
    input  wire logic [AW-1:0]           i_widx,
    input  wire logic [AW-1:0]           i_lo,
    input  wire logic [AW-1:0]           i_hi,
    output stl_pkg::t_ctl                o_ctl,
    output logic signed [VALUE_WIDTH-1:0] o_key,
    output logic [AW-1:0]                o_widx,
    output logic [AW-1:0]                o_lo,
    output logic [AW-1:0]                o_hi
);

    logic signed [VALUE_WIDTH-1:0] r_mem [TABLE_DEPTH];
    logic signed [VALUE_WIDTH-1:0] r_rd;
    logic signed [VALUE_WIDTH-1:0] r_key;
    logic [AW-1:0]                 r_widx;
    logic [AW-1:0]                 r_lo;
    logic [AW-1:0]                 r_hi;
    logic [AW-1:0]                 r_mid;
    stl_pkg::t_ctl                 r_ctl;
    logic [AW:0]                   sum;
    logic [AW-1:0]                 mid;
    logic [AW-1:0]                 n_lo;
    logic [AW-1:0]                 n_hi;
    logic                          open_span;

    always_comb begin
        sum = {1'b0, i_lo} + {1'b0, i_hi};
        mid = sum[AW:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= i_key;
        r_widx <= i_widx;
        r_lo   <= i_lo;
        r_hi   <= i_hi;
        r_mid  <= mid;
        r_rd   <= r_mem[mid];
        if (i_ctl.valid && i_ctl.write) begin
            r_mem[i_widx] <= i_key;
        end
    end

    always_comb begin
        n_lo      = r_lo;
        n_hi      = r_hi;
        open_span = (({1'b0, r_lo} + (AW+1)'(1)) < {1'b0, r_hi});
        // finished intervals stop moving, so extra stages are harmless
        if (!r_ctl.done && open_span) begin
            if (r_key > r_rd) begin
                n_lo = r_mid;
            end else begin
                n_hi = r_mid;
            end
        end
    end

    assign o_ctl  = r_ctl;
    assign o_key  = r_key;
    assign o_widx = r_widx;
    assign o_lo   = n_lo;
    assign o_hi   = n_hi;

endmodule

`default_nettype wire

// ----- rtl/sorted_table_interval_locate.sv -----
// Sorted table interval locator: every beat on start is taken (busy stays low), one per
// clock. A write beat loads one breakpoint and gives no result. A locate beat passes
// log2(TABLE_DEPTH) + 2 register stages: one range check stage, one bisection stage per
// bit of the table index, and the output register. Its result is on o_result with
// o_result_valid high for one cycle, both driven from the output register. Each stage
// holds its own copy of the table, updated as a write beat passes, so beats keep their
// order. The receiver cannot stall.
`default_nettype none

module sorted_table_interval_locate #(
    parameter int TABLE_DEPTH = stl_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = stl_pkg::VALUE_WIDTH_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire stl_pkg::t_req               i_req,
    input  wire                              i_cfg_we,
    input  wire logic [stl_pkg::LEN_W-1:0]   i_cfg_data,
    output logic                             o_result_valid,
    output stl_pkg::t_result                 o_result
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int NSTEP = AW;

    logic [stl_pkg::LEN_W-1:0]     r_len;
    logic [31:0]                   used;
    logic [AW-1:0]                 last;
    logic signed [63:0]            wide;
    logic signed [VALUE_WIDTH-1:0] key_in;
    stl_pkg::t_ctl                 ctl_in;

    stl_pkg::t_ctl                 ctl_s  [NSTEP+1];
    logic signed [VALUE_WIDTH-1:0] key_s  [NSTEP+1];
    logic [AW-1:0]                 widx_s [NSTEP+1];
    logic [AW-1:0]                 lo_s   [NSTEP+1];
    logic [AW-1:0]                 hi_s   [NSTEP+1];

    stl_pkg::t_result              r_res;
    logic                          r_res_valid;
    stl_pkg::t_result              n_res;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= stl_pkg::LEN_RESET;
        end else if (i_cfg_we) begin
            r_len <= i_cfg_data;
        end
    end

    // clamp the length into 1..TABLE_DEPTH
    always_comb begin
        if (r_len == '0) begin
            used = 32'd1;
        end else if (32'(r_len) > 32'(TABLE_DEPTH)) begin
            used = 32'(TABLE_DEPTH);
        end else begin
            used = 32'(r_len);
        end
        last = AW'(used - 32'd1);
    end

    always_comb begin
        wide          = 64'(i_req.item_value);
        key_in        = wide[VALUE_WIDTH-1:0];
        ctl_in        = '0;
        ctl_in.valid  = start;
        ctl_in.locate = (i_req.req_type == stl_pkg::REQ_LOCATE);
        ctl_in.write  = (i_req.req_type == stl_pkg::REQ_WRITE)
                        && (32'(i_req.entry_index) < 32'(TABLE_DEPTH));
    end

    stl_range #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_range (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_in),
        .i_key   (key_in),
        .i_widx  (AW'(i_req.entry_index)),
        .i_last  (last),
        .o_ctl   (ctl_s[0]),
        .o_key   (key_s[0]),
        .o_widx  (widx_s[0]),
        .o_lo    (lo_s[0]),
        .o_hi    (hi_s[0])
    );

    for (genvar g = 0; g < NSTEP; g++) begin : g_step
        stl_step #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl_s[g]),
            .i_key   (key_s[g]),
            .i_widx  (widx_s[g]),
            .i_lo    (lo_s[g]),
            .i_hi    (hi_s[g]),
            .o_ctl   (ctl_s[g+1]),
            .o_key   (key_s[g+1]),
            .o_widx  (widx_s[g+1]),
            .o_lo    (lo_s[g+1]),
            .o_hi    (hi_s[g+1])
        );
    end

    // lo stays at zero for out of range values
    always_comb begin
        n_res.interval_index = stl_pkg::IDX_W'(lo_s[NSTEP]);
        n_res.locate_status  = ctl_s[NSTEP].status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= ctl_s[NSTEP].valid && ctl_s[NSTEP].locate;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_result_valid = r_res_valid;
    assign o_result       = r_res;

endmodule

`default_nettype wire

// ----- sim/sorted_table_interval_locate_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the sorted table interval locator
module sorted_table_interval_locate_tb;
    import stl_pkg::*;

    localparam int DEPTH        = TABLE_DEPTH_DEF;
    localparam int DRAIN_CYCLES = 20;
    localparam int SMALL_PHASES = 12;

    class locate_scoreboard;
        logic signed [ITEM_W-1:0] breakpoints [DEPTH];
        logic [LEN_W-1:0]         length_reg;
        t_result                  expected_q [$];
        int                       errors;

        function new();
            length_reg = LEN_RESET;
            errors     = 0;
        endfunction

        function void set_length(logic [LEN_W-1:0] v);
            length_reg = v;
        endfunction

        function t_result predict_interval(logic signed [ITEM_W-1:0] value);
            int      n;
            int      lo;
            int      hi;
            int      mid;
            t_result res;
            n = int'(length_reg);
            if (n < 1) n = 1;
            if (n > DEPTH) n = DEPTH;
            res.interval_index = '0;
            res.locate_status  = ST_INSIDE;
            if (value <= breakpoints[0]) begin
                res.locate_status = ST_BELOW;
            end else if (value >= breakpoints[n-1]) begin
                res.locate_status = ST_ABOVE;
            end else begin
                lo = 0;
                hi = n - 1;
                while (lo + 1 < hi) begin
                    mid = (lo + hi) / 2;
                    if (value > breakpoints[mid]) lo = mid;
                    else hi = mid;
                end
                res.interval_index = IDX_W'(lo);
            end
            return res;
        endfunction

        // write beats update the table copy, locate beats queue a prediction
        function void note_request(t_req r);
            if (r.req_type == REQ_WRITE) begin
                breakpoints[r.entry_index] = $signed(r.item_value);
            end else begin
                expected_q.insert(expected_q.size(), predict_interval($signed(r.item_value)));
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual index %0d status %0d",
                         $time, got.interval_index, got.locate_status);
                return;
            end
            want = expected_q.pop_front();
            if (got.interval_index !== want.interval_index) begin
                errors++;
                $display("%0t: interval_index mismatch, expected %0d actual %0d",
                         $time, want.interval_index, got.interval_index);
            end
            if (got.locate_status !== want.locate_status) begin
                errors++;
                $display("%0t: locate_status mismatch, expected %0d actual %0d",
                         $time, want.locate_status, got.locate_status);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_req             i_req;
    logic             i_cfg_we;
    logic [LEN_W-1:0] i_cfg_data;
    logic             o_result_valid;
    t_result          o_result;

    locate_scoreboard sb = new();
    int               idle_pct;
    int               write_beats;
    int               locate_beats;
    int               length_writes;

    sorted_table_interval_locate DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req          (i_req),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) sb.check_result(o_result);
    end

    task automatic idle_cycle();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_beat(t_req r);
        while ($urandom_range(99, 0) < idle_pct) idle_cycle();
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        sb.note_request(r);
        if (r.req_type == REQ_WRITE) write_beats++;
        else locate_beats++;
    endtask

    task automatic send_write(int idx, logic [ITEM_W-1:0] v);
        t_req r;
        r.req_type    = REQ_WRITE;
        r.entry_index = IDX_W'(idx);
        r.item_value  = v;
        send_beat(r);
    endtask

    task automatic send_locate(logic [ITEM_W-1:0] v);
        t_req r;
        r.req_type    = REQ_LOCATE;
        r.entry_index = IDX_W'($urandom);
        r.item_value  = v;
        send_beat(r);
    endtask

    // only while idle: results drained, then room for write beats still in flight
    task automatic write_length(logic [LEN_W-1:0] v);
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.set_length(v);
        i_cfg_we <= 1'b0;
        length_writes++;
    endtask

    // non-decreasing breakpoints at entries 0..len-1 with a random spacing scale
    task automatic load_table(int len);
        longint step_max;
        longint room;
        longint v;
        step_max = 64'd4294967294 / len;
        case ($urandom_range(2, 0))
            0: if (step_max > 3) step_max = 3;
            1: if (step_max > 2000) step_max = 2000;
            default: ;
        endcase
        room = 64'd4294967295 - longint'(len) * step_max;
        v = -64'sd2147483648 + (longint'($urandom) % (room + 1));
        for (int i = 0; i < len; i++) begin
            send_write(i, v[ITEM_W-1:0]);
            v = v + (longint'($urandom) % (step_max + 1));
        end
    endtask

    function automatic logic [ITEM_W-1:0] pick_probe(int len);
        int               k;
        logic [ITEM_W-1:0] base;
        k    = $urandom_range(len - 1, 0);
        base = sb.breakpoints[k];
        case ($urandom_range(9, 0))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            3: return base + ($urandom >> $urandom_range(31, 1));
            default: return base + ITEM_W'($urandom_range(2, 0)) - 32'd1;
        endcase
    endfunction

    // mostly locates near breakpoints, some stray writes that may break the ordering
    task automatic run_probes(int len, int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9, 0) == 0) send_write($urandom_range(DEPTH - 1, 0), $urandom);
            else send_locate(pick_probe(len));
        end
    endtask

    initial begin
        int len;
        int code;
        int waited;
        start         <= 1'b0;
        i_req         <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        idle_pct      = 0;
        write_beats   = 0;
        locate_beats  = 0;
        length_writes = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: boundaries of a four entry table
        write_length(LEN_W'(4));
        send_write(0, -32'sd100);
        send_write(1, -32'sd5);
        send_write(2, 32'sd7);
        send_write(3, 32'h7fff_ffff);
        send_locate(32'h8000_0000);
        send_locate(-32'sd100);
        send_locate(-32'sd99);
        send_locate(-32'sd5);
        send_locate(-32'sd4);
        send_locate(32'sd7);
        send_locate(32'sd8);
        send_locate(32'h7fff_fffe);
        send_locate(32'h7fff_ffff);
        write_length(LEN_W'(3));
        send_locate(32'h7fff_ffff);
        send_locate(32'sd7);
        // single entry, then zero length read as one
        write_length(LEN_W'(1));
        send_locate(-32'sd100);
        send_locate(-32'sd101);
        send_locate(-32'sd99);
        write_length(LEN_W'(0));
        send_locate(-32'sd99);
        send_locate(-32'sd100);
        // table no longer ascending
        send_write(1, 32'sd50);
        write_length(LEN_W'(4));
        send_locate(32'sd8);
        send_locate(32'sd60);

        // small tables, reloaded every phase
        for (int p = 0; p < SMALL_PHASES; p++) begin
            case (p % 3)
                0: idle_pct = 0;
                1: idle_pct = 50;
                default: idle_pct = 21;
            endcase
            len = (p == 0) ? 2 : (p == 1) ? 1 : $urandom_range(40, 1);
            code = (len == 1 && $urandom_range(1, 0) == 1) ? 0 : len;
            write_length(LEN_W'(code));
            load_table(len);
            run_probes(len, $urandom_range(30, 15));
        end

        // full table, then lengths over it including codes above the depth
        idle_pct = 21;
        write_length(LEN_W'(DEPTH));
        load_table(DEPTH);
        run_probes(DEPTH, 40);
        idle_pct = 0;
        write_length(LEN_W'(2047));
        run_probes(DEPTH, 20);
        for (int q = 0; q < 4; q++) begin
            idle_pct = (q % 2 == 0) ? 50 : 0;
            len = (q == 0) ? DEPTH : $urandom_range(DEPTH - 1, 1);
            code = (len == DEPTH) ? $urandom_range(2047, DEPTH) : len;
            write_length(LEN_W'(code));
            run_probes(len, 20);
        end

        start <= 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < 500) begin
            @(posedge i_clk);
            waited++;
        end
        if (sb.pending() != 0) begin
            $display("%0t: %0d locate results never arrived, expected %0d actual 0",
                     $time, sb.pending(), sb.pending());
            sb.errors += sb.pending();
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d write beats and %0d locate beats over %0d length settings",
                 write_beats, locate_beats, length_writes);
        $display("lengths 0, 1, small, full depth and above depth; sender gaps of 0, 21, 50 pct");
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
